>>> hdl/sccr_pkg.sv
// shared types, constants and saturating Q48.16 helpers for the segment/circle
// collision block; no dependencies
package sccr_pkg;

  localparam int Q_W       = 64;
  localparam int FRAC_BITS = 16;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int RAD_W     = 31;
  localparam int IO_W      = 32;

  typedef logic signed [Q_W-1:0] q_t;
  typedef logic signed [IO_W-1:0] io_t;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 2'd2;

  localparam logic [RAD_W-1:0] RADIUS_RST = 31'd65536;

  localparam q_t ONE_Q   = 64'sh0000_0000_0001_0000;
  localparam q_t Q_MAX   = 64'sh7fff_ffff_ffff_ffff;
  localparam q_t Q_MIN   = 64'sh8000_0000_0000_0000;
  localparam q_t S32_MAX = 64'sh0000_0000_7fff_ffff;
  localparam q_t S32_MIN = 64'shffff_ffff_8000_0000;

  // unit latencies in cycles
  localparam int MUL_LAT   = 4;
  localparam int SQRT_BITS = 40;
  localparam int SQRT_LAT  = SQRT_BITS;
  localparam int DIV_BITS  = 2 * Q_W;
  localparam int DIV_LAT   = DIV_BITS + 2;

  function automatic q_t sx32(io_t v);
    return {{(Q_W-IO_W){v[IO_W-1]}}, v};
  endfunction

  function automatic q_t add_sat(q_t a, q_t b);
    logic [Q_W:0] s;
    s = {a[Q_W-1], a} + {b[Q_W-1], b};
    if (s[Q_W] != s[Q_W-1]) return s[Q_W] ? Q_MIN : Q_MAX;
    return s[Q_W-1:0];
  endfunction

  function automatic q_t sub_sat(q_t a, q_t b);
    logic [Q_W:0] s;
    s = {a[Q_W-1], a} - {b[Q_W-1], b};
    if (s[Q_W] != s[Q_W-1]) return s[Q_W] ? Q_MIN : Q_MAX;
    return s[Q_W-1:0];
  endfunction

  function automatic logic [Q_W-1:0] mag(q_t x);
    return x[Q_W-1] ? -x : x;
  endfunction

  function automatic q_t from_mag(logic [Q_W-1:0] m, logic neg, logic over);
    q_t r;
    if (neg) begin
      if (over || m[Q_W-1]) r = Q_MIN;
      else r = -q_t'(m);
    end else if (over || m[Q_W-1]) begin
      r = Q_MAX;
    end else begin
      r = q_t'(m);
    end
    return r;
  endfunction

  function automatic io_t sat32(q_t v);
    q_t r;
    if (v > S32_MAX) r = S32_MAX;
    else if (v < S32_MIN) r = S32_MIN;
    else r = v;
    return r[IO_W-1:0];
  endfunction

endpackage

>>> hdl/sccr_if.sv
// valid/ready channel interfaces for move requests and collision results
// depends on sccr_pkg
interface sccr_in_if;
  logic              valid;
  logic              ready;
  logic              mode;
  sccr_pkg::io_t     origin_x;
  sccr_pkg::io_t     origin_y;
  sccr_pkg::io_t     end_x;
  sccr_pkg::io_t     end_y;

  modport source (output valid, mode, origin_x, origin_y, end_x, end_y, input ready);
  modport sink (input valid, mode, origin_x, origin_y, end_x, end_y, output ready);
endinterface

interface sccr_out_if;
  logic              valid;
  logic              ready;
  logic              hit;
  sccr_pkg::io_t     hit_time;
  sccr_pkg::io_t     point_x;
  sccr_pkg::io_t     point_y;
  sccr_pkg::io_t     mirror_x;
  sccr_pkg::io_t     mirror_y;

  modport source (output valid, hit, hit_time, point_x, point_y, mirror_x, mirror_y,
                  input ready);
  modport sink (input valid, hit, hit_time, point_x, point_y, mirror_x, mirror_y,
                output ready);
endinterface

>>> hdl/sccr_mul.sv
// pipelined saturating Q48.16 multiplier, 64 x 64 bit split into 32 x 32 products
// depends on sccr_pkg
module sccr_mul (
  input  logic          clk_i,
  input  logic          en_i,
  input  sccr_pkg::q_t  a_i,
  input  sccr_pkg::q_t  b_i,
  output sccr_pkg::q_t  p_o
);
  import sccr_pkg::*;

  localparam int H_W = Q_W / 2;

  logic [Q_W-1:0]   ma_q, mb_q;
  logic             neg1_q, neg2_q, neg3_q;
  logic [Q_W-1:0]   pp00_q, pp01_q, pp10_q, pp11_q;
  logic [2*Q_W-1:0] sum_q;
  q_t               p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ma_q   <= mag(a_i);
      mb_q   <= mag(b_i);
      neg1_q <= a_i[Q_W-1] ^ b_i[Q_W-1];
      pp00_q <= {{H_W{1'b0}}, ma_q[H_W-1:0]} * {{H_W{1'b0}}, mb_q[H_W-1:0]};
      pp01_q <= {{H_W{1'b0}}, ma_q[H_W-1:0]} * {{H_W{1'b0}}, mb_q[Q_W-1:H_W]};
      pp10_q <= {{H_W{1'b0}}, ma_q[Q_W-1:H_W]} * {{H_W{1'b0}}, mb_q[H_W-1:0]};
      pp11_q <= {{H_W{1'b0}}, ma_q[Q_W-1:H_W]} * {{H_W{1'b0}}, mb_q[Q_W-1:H_W]};
      neg2_q <= neg1_q;
      sum_q  <= {{Q_W{1'b0}}, pp00_q}
              + {{H_W{1'b0}}, pp01_q, {H_W{1'b0}}}
              + {{H_W{1'b0}}, pp10_q, {H_W{1'b0}}}
              + {pp11_q, {Q_W{1'b0}}};
      neg3_q <= neg2_q;
      // drop the fraction, anything above the 64-bit window saturates
      p_q    <= from_mag(sum_q[Q_W+FRAC_BITS-1:FRAC_BITS], neg3_q,
                         |sum_q[2*Q_W-1:Q_W+FRAC_BITS]);
    end
  end

  assign p_o = p_q;
endmodule

>>> hdl/sccr_sqrt.sv
// pipelined square root, one result bit per stage: floor(sqrt(x * 2^16))
// depends on sccr_pkg
module sccr_sqrt (
  input  logic          clk_i,
  input  logic          en_i,
  input  sccr_pkg::q_t  x_i,
  output sccr_pkg::q_t  s_o
);
  import sccr_pkg::*;

  localparam int REM_W = SQRT_BITS + 4;
  localparam int N_W   = Q_W + FRAC_BITS;

  logic [REM_W-1:0]     rem_q  [SQRT_BITS];
  logic [SQRT_BITS-1:0] root_q [SQRT_BITS];
  logic [Q_W-1:0]       x_q    [SQRT_BITS];

  for (genvar s = 0; s < SQRT_BITS; s++) begin : g_step
    localparam int I = SQRT_BITS - 1 - s;
    logic [REM_W-1:0]     rem_in, rem_sh, trial;
    logic [SQRT_BITS-1:0] root_in;
    logic [Q_W-1:0]       x_in;
    logic [N_W-1:0]       n;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = x_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign x_in    = x_q[s-1];
    end

    assign n      = {x_in, {FRAC_BITS{1'b0}}};
    assign rem_sh = {rem_in[REM_W-3:0], n[2*I+1], n[2*I]};
    assign trial  = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[s] <= x_in;
        if (rem_sh >= trial) begin
          rem_q[s]  <= rem_sh - trial;
          root_q[s] <= {root_in[SQRT_BITS-2:0], 1'b1};
        end else begin
          rem_q[s]  <= rem_sh;
          root_q[s] <= {root_in[SQRT_BITS-2:0], 1'b0};
        end
      end
    end
  end

  assign s_o = {{(Q_W-SQRT_BITS){1'b0}}, root_q[SQRT_BITS-1]};
endmodule

>>> hdl/sccr_div.sv
// pipelined saturating Q48.16 divider, restoring, one quotient bit per stage
// depends on sccr_pkg
module sccr_div (
  input  logic          clk_i,
  input  logic          en_i,
  input  sccr_pkg::q_t  n_i,
  input  sccr_pkg::q_t  d_i,
  output sccr_pkg::q_t  q_o
);
  import sccr_pkg::*;

  typedef struct packed {
    logic neg;
    logic n_zero;
    logic d_zero;
    logic n_neg;
  } div_flags_t;

  logic [Q_W-1:0] un_q, ud_q;
  div_flags_t     fl_q;

  logic [Q_W-1:0] rem_s_q  [DIV_BITS];
  logic [Q_W-1:0] quo_s_q  [DIV_BITS];
  logic           over_s_q [DIV_BITS];
  logic [Q_W-1:0] un_s_q   [DIV_BITS];
  logic [Q_W-1:0] ud_s_q   [DIV_BITS];
  div_flags_t     fl_s_q   [DIV_BITS];
  q_t             q_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      un_q        <= mag(n_i);
      ud_q        <= mag(d_i);
      fl_q.neg    <= n_i[Q_W-1] ^ d_i[Q_W-1];
      fl_q.n_zero <= (n_i == '0);
      fl_q.d_zero <= (d_i == '0);
      fl_q.n_neg  <= n_i[Q_W-1];
    end
  end

  for (genvar j = 0; j < DIV_BITS; j++) begin : g_step
    localparam int I = DIV_BITS - 1 - j;
    logic [Q_W-1:0] rem_in, quo_in, un_in, ud_in;
    logic           over_in, nbit, ge;
    logic [Q_W:0]   rem_sh, rem_sub;
    div_flags_t     fl_in;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign quo_in  = '0;
      assign over_in = 1'b0;
      assign un_in   = un_q;
      assign ud_in   = ud_q;
      assign fl_in   = fl_q;
    end else begin : g_next
      assign rem_in  = rem_s_q[j-1];
      assign quo_in  = quo_s_q[j-1];
      assign over_in = over_s_q[j-1];
      assign un_in   = un_s_q[j-1];
      assign ud_in   = ud_s_q[j-1];
      assign fl_in   = fl_s_q[j-1];
    end

    // dividend is the magnitude shifted up by the fraction width
    if (I >= FRAC_BITS && I < Q_W + FRAC_BITS) begin : g_bit
      assign nbit = un_in[I-FRAC_BITS];
    end else begin : g_zero
      assign nbit = 1'b0;
    end

    assign rem_sh  = {rem_in, nbit};
    assign ge      = (rem_sh >= {1'b0, ud_in});
    assign rem_sub = rem_sh - {1'b0, ud_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_s_q[j]  <= ge ? rem_sub[Q_W-1:0] : rem_sh[Q_W-1:0];
        quo_s_q[j]  <= {quo_in[Q_W-2:0], ge};
        over_s_q[j] <= over_in | quo_in[Q_W-1];
        un_s_q[j]   <= un_in;
        ud_s_q[j]   <= ud_in;
        fl_s_q[j]   <= fl_in;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (fl_s_q[DIV_BITS-1].n_zero) begin
        q_q <= '0;
      end else if (fl_s_q[DIV_BITS-1].d_zero) begin
        q_q <= fl_s_q[DIV_BITS-1].n_neg ? Q_MIN : Q_MAX;
      end else begin
        q_q <= from_mag(quo_s_q[DIV_BITS-1], fl_s_q[DIV_BITS-1].neg,
                        over_s_q[DIV_BITS-1]);
      end
    end
  end

  assign q_o = q_q;
endmodule

>>> hdl/segment_circle_collision_reflect_top.sv
// top level: config registers, stage pipeline and the arithmetic units
// depends on sccr_pkg, sccr_if, sccr_mul, sccr_sqrt, sccr_div

// Segment against circle collision with reflection, Q16.16 fixed point. The
// block accepts one move transaction per clock while the pipeline is not held
// and returns exactly one result transaction for each, in order. The path from
// accept to result valid runs through the 40-stage square root and then the
// dividers (128 quotient stages plus an input and an output register each)
// for the time and then for the reflection factor. The whole pipeline advances
// together and holds while a finished result waits to be taken. The circle
// registers are read both at the first stages and at the hit point stage, so
// write them only while no transaction is in flight.
module segment_circle_collision_reflect_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sccr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sccr_pkg::CFG_W-1:0]        cfg_data_i,
  sccr_in_if.sink                           in_ch,
  sccr_out_if.source                        out_ch
);
  import sccr_pkg::*;

  localparam int S_AH   = MUL_LAT + 1;
  localparam int S_C    = S_AH + 1;
  localparam int S_DISC = S_C + MUL_LAT + 1;
  localparam int S_Q1   = S_DISC + SQRT_LAT + 1;
  localparam int S_Q2   = S_Q1 + 1;
  localparam int S_SEL  = S_Q2 + DIV_LAT + 1;
  localparam int S_P    = S_SEL + MUL_LAT + 1;
  localparam int S_W    = S_P + 1;
  localparam int S_WW   = S_W + MUL_LAT + 1;
  localparam int S_K    = S_WW + DIV_LAT + 1;
  localparam int S_MX   = S_K + MUL_LAT + 1;
  localparam int S_OUT  = S_MX + 1;

  typedef struct packed {
    logic mode;
    io_t  ox;
    io_t  oy;
    io_t  ex;
    io_t  ey;
    q_t   a;
    q_t   h;
    q_t   c;
    q_t   tmp;
    logic hit;
    q_t   t;
    q_t   px;
    q_t   py;
    q_t   wx;
    q_t   wy;
    q_t   vx;
    q_t   vy;
    q_t   ww;
    q_t   mx;
    q_t   my;
  } ctx_t;

  typedef struct packed {
    logic hit;
    q_t   t;
  } sel_t;

  function automatic sel_t pick_time(logic internal, q_t t1, q_t t2);
    sel_t r;
    q_t   sum;
    r.hit = 1'b0;
    r.t   = '0;
    sum   = t1 + t2;
    if (internal) begin
      if (t1 > t2) begin
        if (t1 < ONE_Q) begin r.hit = 1'b1; r.t = t1; end
      end else if (t2 < ONE_Q) begin
        r.hit = 1'b1; r.t = t2;
      end
    end else if ((t1 < 0 && t2 > 0) || (t1 > 0 && t2 < 0)) begin
      // started inside: take the backward time if the move heads out
      if (t1 < 0 && sum > 0) begin r.hit = 1'b1; r.t = t1; end
      else if (t2 < 0 && sum > 0) begin r.hit = 1'b1; r.t = t2; end
    end else if (!(t1 <= 0 && t2 <= 0)) begin
      if (t1 <= t2 && t1 < ONE_Q) begin r.hit = 1'b1; r.t = t1; end
      else if (t2 < t1 && t2 < ONE_Q) begin r.hit = 1'b1; r.t = t2; end
    end
    return r;
  endfunction

  io_t              cx_q, cy_q;
  logic [RAD_W-1:0] rad_q;

  ctx_t         ctx_q [S_MX+1];
  ctx_t         ctx_d [S_MX+1];
  logic [S_OUT:0] vld_q;
  logic         en;

  q_t dx0, dy0, rx0, ry0, rr0, dx3, dy3;
  q_t p_dxdx, p_dydy, p_rxdx, p_rydy, p_rxrx, p_ryry, p_rr;
  q_t p_hh, p_ac, s_root, t1, t2;
  q_t p_dxt, p_dyt, p_wxwx, p_wywy, p_vxwx, p_vywy, k_res, p_kwx, p_kwy;
  sel_t sel;

  logic hit_q;
  io_t  time_q, pt_x_q, pt_y_q, mir_x_q, mir_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q  <= '0;
      cy_q  <= '0;
      rad_q <= RADIUS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CENTRE_X: cx_q  <= cfg_data_i;
        CFG_CENTRE_Y: cy_q  <= cfg_data_i;
        CFG_RADIUS:   rad_q <= cfg_data_i[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  assign en          = !vld_q[S_OUT] || out_ch.ready;
  assign in_ch.ready = en;

  // operands of the first and third multiply groups
  assign dx0 = sx32(ctx_q[0].ex) - sx32(ctx_q[0].ox);
  assign dy0 = sx32(ctx_q[0].ey) - sx32(ctx_q[0].oy);
  assign rx0 = sx32(ctx_q[0].ox) - sx32(cx_q);
  assign ry0 = sx32(ctx_q[0].oy) - sx32(cy_q);
  assign rr0 = {{(Q_W-RAD_W){1'b0}}, rad_q};
  assign dx3 = sx32(ctx_q[S_P-1-MUL_LAT].ex) - sx32(ctx_q[S_P-1-MUL_LAT].ox);
  assign dy3 = sx32(ctx_q[S_P-1-MUL_LAT].ey) - sx32(ctx_q[S_P-1-MUL_LAT].oy);

  sccr_mul u_mul_dxdx (.clk_i, .en_i(en), .a_i(dx0), .b_i(dx0), .p_o(p_dxdx));
  sccr_mul u_mul_dydy (.clk_i, .en_i(en), .a_i(dy0), .b_i(dy0), .p_o(p_dydy));
  sccr_mul u_mul_rxdx (.clk_i, .en_i(en), .a_i(rx0), .b_i(dx0), .p_o(p_rxdx));
  sccr_mul u_mul_rydy (.clk_i, .en_i(en), .a_i(ry0), .b_i(dy0), .p_o(p_rydy));
  sccr_mul u_mul_rxrx (.clk_i, .en_i(en), .a_i(rx0), .b_i(rx0), .p_o(p_rxrx));
  sccr_mul u_mul_ryry (.clk_i, .en_i(en), .a_i(ry0), .b_i(ry0), .p_o(p_ryry));
  sccr_mul u_mul_rr   (.clk_i, .en_i(en), .a_i(rr0), .b_i(rr0), .p_o(p_rr));

  sccr_mul u_mul_hh (.clk_i, .en_i(en), .a_i(ctx_q[S_C].h), .b_i(ctx_q[S_C].h),
                     .p_o(p_hh));
  sccr_mul u_mul_ac (.clk_i, .en_i(en), .a_i(ctx_q[S_C].a), .b_i(ctx_q[S_C].c),
                     .p_o(p_ac));

  sccr_sqrt u_sqrt (.clk_i, .en_i(en), .x_i(ctx_q[S_DISC].tmp), .s_o(s_root));

  sccr_div u_div_t1 (.clk_i, .en_i(en), .n_i(ctx_q[S_Q2].tmp), .d_i(ctx_q[S_Q2].a),
                     .q_o(t1));
  sccr_div u_div_t2 (.clk_i, .en_i(en), .n_i(ctx_q[S_Q2].c), .d_i(ctx_q[S_Q2].tmp),
                     .q_o(t2));

  sccr_mul u_mul_dxt (.clk_i, .en_i(en), .a_i(dx3), .b_i(ctx_q[S_SEL].t), .p_o(p_dxt));
  sccr_mul u_mul_dyt (.clk_i, .en_i(en), .a_i(dy3), .b_i(ctx_q[S_SEL].t), .p_o(p_dyt));

  sccr_mul u_mul_wxwx (.clk_i, .en_i(en), .a_i(ctx_q[S_W].wx), .b_i(ctx_q[S_W].wx),
                       .p_o(p_wxwx));
  sccr_mul u_mul_wywy (.clk_i, .en_i(en), .a_i(ctx_q[S_W].wy), .b_i(ctx_q[S_W].wy),
                       .p_o(p_wywy));
  sccr_mul u_mul_vxwx (.clk_i, .en_i(en), .a_i(ctx_q[S_W].vx), .b_i(ctx_q[S_W].wx),
                       .p_o(p_vxwx));
  sccr_mul u_mul_vywy (.clk_i, .en_i(en), .a_i(ctx_q[S_W].vy), .b_i(ctx_q[S_W].wy),
                       .p_o(p_vywy));

  sccr_div u_div_k (.clk_i, .en_i(en), .n_i(ctx_q[S_WW].tmp), .d_i(ctx_q[S_WW].ww),
                    .q_o(k_res));

  sccr_mul u_mul_kwx (.clk_i, .en_i(en), .a_i(ctx_q[S_K].tmp), .b_i(ctx_q[S_K].wx),
                      .p_o(p_kwx));
  sccr_mul u_mul_kwy (.clk_i, .en_i(en), .a_i(ctx_q[S_K].tmp), .b_i(ctx_q[S_K].wy),
                      .p_o(p_kwy));

  assign sel = pick_time(ctx_q[S_SEL-1].mode, t1, t2);

  always_comb begin
    ctx_d[0]      = '0;
    ctx_d[0].mode = in_ch.mode;
    ctx_d[0].ox   = in_ch.origin_x;
    ctx_d[0].oy   = in_ch.origin_y;
    ctx_d[0].ex   = in_ch.end_x;
    ctx_d[0].ey   = in_ch.end_y;
    for (int k = 1; k <= S_MX; k++) ctx_d[k] = ctx_q[k-1];

    ctx_d[S_AH].a   = add_sat(p_dxdx, p_dydy);
    ctx_d[S_AH].h   = add_sat(p_rxdx, p_rydy);
    ctx_d[S_AH].c   = add_sat(p_rxrx, p_ryry);
    ctx_d[S_AH].tmp = p_rr;
    ctx_d[S_C].c    = sub_sat(ctx_q[S_C-1].c, ctx_q[S_C-1].tmp);

    ctx_d[S_DISC].tmp  = sub_sat(p_hh, p_ac);
    ctx_d[S_DISC+1].hit = !ctx_q[S_DISC].tmp[Q_W-1] && (ctx_q[S_DISC].tmp != '0);

    // stable root: q = -(h + sign(h) * sqrt(disc))
    if (!ctx_q[S_Q1-1].h[Q_W-1] && ctx_q[S_Q1-1].h != '0) begin
      ctx_d[S_Q1].tmp = add_sat(ctx_q[S_Q1-1].h, s_root);
      ctx_d[S_Q2].tmp = -ctx_q[S_Q2-1].tmp;
    end else begin
      ctx_d[S_Q1].tmp = sub_sat(s_root, ctx_q[S_Q1-1].h);
      ctx_d[S_Q2].tmp = ctx_q[S_Q2-1].tmp;
    end
    if (ctx_q[S_Q2-1].h[Q_W-1] || ctx_q[S_Q2-1].h == '0) ctx_d[S_Q2].tmp = ctx_q[S_Q2-1].tmp;
    else ctx_d[S_Q2].tmp = -ctx_q[S_Q2-1].tmp;

    ctx_d[S_SEL].hit = ctx_q[S_SEL-1].hit & sel.hit;
    ctx_d[S_SEL].t   = sel.t;

    ctx_d[S_P].px = add_sat(sx32(ctx_q[S_P-1].ox), p_dxt);
    ctx_d[S_P].py = add_sat(sx32(ctx_q[S_P-1].oy), p_dyt);

    ctx_d[S_W].wx = sub_sat(ctx_q[S_W-1].px, sx32(cx_q));
    ctx_d[S_W].wy = sub_sat(ctx_q[S_W-1].py, sx32(cy_q));
    ctx_d[S_W].vx = sub_sat(sx32(ctx_q[S_W-1].ex), ctx_q[S_W-1].px);
    ctx_d[S_W].vy = sub_sat(sx32(ctx_q[S_W-1].ey), ctx_q[S_W-1].py);

    ctx_d[S_WW].ww  = add_sat(p_wxwx, p_wywy);
    ctx_d[S_WW].tmp = add_sat(p_vxwx, p_vywy);

    ctx_d[S_K].tmp = add_sat(k_res, k_res);

    // degenerate normal leaves the end point as it is
    if (ctx_q[S_MX-1].ww != '0) begin
      ctx_d[S_MX].mx = sub_sat(sx32(ctx_q[S_MX-1].ex), p_kwx);
      ctx_d[S_MX].my = sub_sat(sx32(ctx_q[S_MX-1].ey), p_kwy);
    end else begin
      ctx_d[S_MX].mx = sx32(ctx_q[S_MX-1].ex);
      ctx_d[S_MX].my = sx32(ctx_q[S_MX-1].ey);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctx_q <= ctx_d;
      hit_q <= ctx_q[S_MX].hit;
      if (ctx_q[S_MX].hit) begin
        time_q  <= sat32(ctx_q[S_MX].t);
        pt_x_q  <= sat32(ctx_q[S_MX].px);
        pt_y_q  <= sat32(ctx_q[S_MX].py);
        mir_x_q <= sat32(ctx_q[S_MX].mx);
        mir_y_q <= sat32(ctx_q[S_MX].my);
      end else begin
        time_q  <= '0;
        pt_x_q  <= '0;
        pt_y_q  <= '0;
        mir_x_q <= '0;
        mir_y_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[S_OUT-1:0], in_ch.valid};
    end
  end

  assign out_ch.valid    = vld_q[S_OUT];
  assign out_ch.hit      = hit_q;
  assign out_ch.hit_time = time_q;
  assign out_ch.point_x  = pt_x_q;
  assign out_ch.point_y  = pt_y_q;
  assign out_ch.mirror_x = mir_x_q;
  assign out_ch.mirror_y = mir_y_q;
endmodule
